>>> src/omni3_pkg.sv
// Shared constants, widths and helper functions for the three-wheel omni odometry block.
`timescale 1ns / 1ps
`default_nettype none

package omni3_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int IDX_W = 8;
  localparam int NUM_W = 96;
  localparam int DEN_W = 66;
  localparam int QUOT_W = 33;
  localparam int ANG_W = 36;
  localparam int CRD_W = 34;

  localparam logic [IDX_W-1:0] REG_INV_RADIUS = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_CENTER_DIST = IDX_W'(1);
  localparam logic [31:0] INV_RADIUS_RESET = 32'd65536;
  localparam logic [31:0] CENTER_DIST_RESET = 32'd65536;

  localparam logic signed [ANG_W-1:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30 = 36'sd6746518852;
  localparam logic signed [ANG_W-1:0] THIRD_TURN_Q30 = 36'sd2248839617;
  localparam logic signed [ANG_W-1:0] TWO_THIRD_TURN_Q30 = 36'sd4497679235;
  localparam logic signed [CRD_W-1:0] GAIN_Q30 = 34'sd652032874;

  // Offset of each wheel axis from the heading.
  function automatic logic signed [ANG_W-1:0] wheel_offset(input int i);
    case (i)
      1: wheel_offset = THIRD_TURN_Q30;
      2: wheel_offset = TWO_THIRD_TURN_Q30;
      default: wheel_offset = '0;
    endcase
  endfunction

  // Arctangent of 2^-i in Q30.
  function automatic logic signed [CRD_W-1:0] step_angle(input int i);
    logic signed [CRD_W-1:0] one;
    one = CRD_W'(1);
    case (i)
      0: step_angle = 34'sd843314857;
      1: step_angle = 34'sd497837829;
      2: step_angle = 34'sd263043837;
      3: step_angle = 34'sd133525159;
      4: step_angle = 34'sd67021687;
      5: step_angle = 34'sd33543516;
      6: step_angle = 34'sd16775851;
      7: step_angle = 34'sd8388437;
      8: step_angle = 34'sd4194283;
      9: step_angle = 34'sd2097149;
      10: step_angle = 34'sd1048576;
      default: begin
        if (i <= 30) begin
          step_angle = one << (30 - i);
        end else begin
          step_angle = '0;
        end
      end
    endcase
  endfunction

  // Signed 32-bit result from a quotient magnitude, with saturation.
  function automatic logic signed [31:0] sat_quot(input logic [QUOT_W-1:0] q,
                                                  input logic ovf, input logic neg);
    logic [QUOT_W-1:0] lim;
    lim = QUOT_W'(33'h0_8000_0000);
    if (neg) begin
      if (ovf || q > lim) begin
        sat_quot = 32'sh8000_0000;
      end else begin
        sat_quot = $signed(32'(~q + QUOT_W'(1)));
      end
    end else begin
      if (ovf || q >= lim) begin
        sat_quot = 32'sh7fff_ffff;
      end else begin
        sat_quot = $signed(q[31:0]);
      end
    end
  endfunction

endpackage

`default_nettype wire

>>> src/omni3_if.sv
// Valid/ready channel interfaces for wheel samples and odometry results.
`timescale 1ns / 1ps
`default_nettype none

interface omni3_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] wheel_speed_one;
  logic signed [31:0] wheel_speed_two;
  logic signed [31:0] wheel_speed_three;
  logic signed [31:0] heading;

  modport source(output valid, wheel_speed_one, wheel_speed_two, wheel_speed_three, heading,
                 input ready);
  modport sink(input valid, wheel_speed_one, wheel_speed_two, wheel_speed_three, heading,
               output ready);
endinterface

interface omni3_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] speed_x;
  logic signed [31:0] speed_y;
  logic signed [31:0] turn_rate;
  logic singular;

  modport source(output valid, speed_x, speed_y, turn_rate, singular, input ready);
  modport sink(input valid, speed_x, speed_y, turn_rate, singular, output ready);
endinterface

`default_nettype wire

>>> src/omni_three_wheel_odometry.sv
// Top level: CORDIC, products and three pipelined dividers for omni odometry.
// Throughput is one item per cycle while the output is not stalled; one CORDIC stage
// per rotation step and one divider stage per quotient bit set the depth. A stalled
// output freezes the whole pipeline.
// Reset clears the valid bits and loads both registers with 1.0 (Q16.16).
`timescale 1ns / 1ps
`default_nettype none

module omni_three_wheel_odometry #(
  parameter int CORDIC_STEPS = omni3_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  omni3_in_if.sink sample,
  omni3_out_if.source result,
  input  logic wr_en,
  input  logic [omni3_pkg::IDX_W-1:0] wr_index,
  input  logic [31:0] wr_data
);

  localparam int N = CORDIC_STEPS;
  localparam int AW = omni3_pkg::ANG_W;
  localparam int CW = omni3_pkg::CRD_W;
  localparam int DIV_LAT = omni3_pkg::QUOT_W + 1;
  localparam int DEPTH = N + 8 + DIV_LAT;

  logic [31:0] inv_radius;
  logic [31:0] center_dist;
  logic [DEPTH-1:0] vld;
  logic [DIV_LAT-1:0] sing_d;
  logic en;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_radius <= omni3_pkg::INV_RADIUS_RESET;
      center_dist <= omni3_pkg::CENTER_DIST_RESET;
    end else if (wr_en) begin
      if (wr_index == omni3_pkg::REG_INV_RADIUS) begin
        inv_radius <= wr_data;
      end else if (wr_index == omni3_pkg::REG_CENTER_DIST) begin
        center_dist <= wr_data;
      end
    end
  end

  assign en = !vld[DEPTH-1] || result.ready;
  assign sample.ready = en;
  assign result.valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], sample.valid};
    end
  end

  // Wheel angles h + a_i in Q30.
  logic signed [AW-1:0] ang1 [0:2];
  logic signed [31:0] w1 [0:2];
  logic signed [AW-1:0] hq;
  assign hq = $signed({{2{sample.heading[31]}}, sample.heading, 2'b00});

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ang1[i] <= hq + omni3_pkg::wheel_offset(i);
      end
      w1[0] <= sample.wheel_speed_one;
      w1[1] <= sample.wheel_speed_two;
      w1[2] <= sample.wheel_speed_three;
    end
  end

  // Truncating remainder by a full turn, then wrap into [-pi, pi].
  logic signed [AW-1:0] red [0:2];
  logic signed [AW-1:0] r2 [0:2];
  logic signed [31:0] w2 [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      red[i] = ang1[i];
      if (ang1[i] >= omni3_pkg::TWO_PI_Q30) begin
        red[i] = ang1[i] - omni3_pkg::TWO_PI_Q30;
      end else if (ang1[i] <= -omni3_pkg::TWO_PI_Q30) begin
        red[i] = ang1[i] + omni3_pkg::TWO_PI_Q30;
      end
      if (red[i] > omni3_pkg::PI_Q30) begin
        red[i] = red[i] - omni3_pkg::TWO_PI_Q30;
      end else if (red[i] < -omni3_pkg::PI_Q30) begin
        red[i] = red[i] + omni3_pkg::TWO_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2 <= red;
      w2 <= w1;
    end
  end

  // CORDIC rotation stages; index 0 holds the folded start angle.
  logic signed [CW-1:0] cx [0:N][0:2];
  logic signed [CW-1:0] cy [0:N][0:2];
  logic signed [CW-1:0] cz [0:N][0:2];
  logic [2:0] cflip [0:N];
  logic signed [31:0] cw [0:N][0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cx[0][i] <= omni3_pkg::GAIN_Q30;
        cy[0][i] <= '0;
        if (r2[i] > omni3_pkg::HALF_PI_Q30) begin
          cz[0][i] <= CW'(r2[i] - omni3_pkg::PI_Q30);
          cflip[0][i] <= 1'b1;
        end else if (r2[i] < -omni3_pkg::HALF_PI_Q30) begin
          cz[0][i] <= CW'(r2[i] + omni3_pkg::PI_Q30);
          cflip[0][i] <= 1'b1;
        end else begin
          cz[0][i] <= CW'(r2[i]);
          cflip[0][i] <= 1'b0;
        end
      end
      cw[0] <= w2;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (!cz[k][i][CW-1]) begin
            cx[k+1][i] <= cx[k][i] - (cy[k][i] >>> k);
            cy[k+1][i] <= cy[k][i] + (cx[k][i] >>> k);
            cz[k+1][i] <= cz[k][i] - omni3_pkg::step_angle(k);
          end else begin
            cx[k+1][i] <= cx[k][i] + (cy[k][i] >>> k);
            cy[k+1][i] <= cy[k][i] - (cx[k][i] >>> k);
            cz[k+1][i] <= cz[k][i] + omni3_pkg::step_angle(k);
          end
        end
        cflip[k+1] <= cflip[k];
        cw[k+1] <= cw[k];
      end
    end
  end

  // Undo the fold and drop to Q29.
  logic signed [31:0] cf [0:2];
  logic signed [31:0] sf [0:2];
  logic signed [31:0] wf [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (cflip[N][i]) begin
          cf[i] <= 32'((-cx[N][i]) >>> 1);
          sf[i] <= 32'((-cy[N][i]) >>> 1);
        end else begin
          cf[i] <= 32'(cx[N][i] >>> 1);
          sf[i] <= 32'(cy[N][i] >>> 1);
        end
      end
      wf <= cw[N];
    end
  end

  // Products of the wheel speeds with sin and cos.
  logic signed [63:0] ps [0:2];
  logic signed [63:0] pc [0:2];
  logic [31:0] cm3;
  logic signed [33:0] wsum;
  logic c0neg;
  logic c0zero;
  logic [31:0] c0abs;
  assign c0abs = cf[0][31] ? 32'(-cf[0]) : 32'(cf[0]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ps[i] <= sf[i] * wf[i];
        pc[i] <= cf[i] * wf[i];
      end
      cm3 <= 32'({c0abs, 1'b0} + {1'b0, c0abs});
      wsum <= 34'(wf[0]) + 34'(wf[1]) + 34'(wf[2]);
      c0neg <= cf[0][31];
      c0zero <= cf[0] == '0;
    end
  end

  // Sums and divisors.
  logic signed [63:0] sn;
  logic signed [63:0] cn;
  logic [63:0] den_xy;
  logic [63:0] den_lr;
  logic signed [33:0] wsum_s;
  logic c0neg_s;
  logic sing_s;

  always_ff @(posedge clk) begin
    if (en) begin
      sn <= ps[0] + ps[1] + ps[2];
      cn <= pc[0] + pc[1] + pc[2];
      den_xy <= cm3 * inv_radius;
      den_lr <= center_dist * inv_radius;
      wsum_s <= wsum;
      c0neg_s <= c0neg;
      sing_s <= c0zero || center_dist == '0 || inv_radius == '0;
    end
  end

  // Dividend magnitudes, signs and the turn-rate divisor with its factor of three.
  logic [63:0] sn_abs;
  logic [63:0] cn_abs;
  logic [33:0] w_abs;
  assign sn_abs = sn[63] ? 64'(-sn) : 64'(sn);
  assign cn_abs = cn[63] ? 64'(-cn) : 64'(cn);
  assign w_abs = wsum_s[33] ? 34'(-wsum_s) : 34'(wsum_s);

  logic [omni3_pkg::NUM_W-1:0] num_x, num_y, num_w;
  logic [omni3_pkg::DEN_W-1:0] dxy, dom;
  logic neg_x, neg_y, neg_w, sing_n;

  always_ff @(posedge clk) begin
    if (en) begin
      num_x <= {16'd0, sn_abs[62:0], 17'd0};
      num_y <= {16'd0, cn_abs[62:0], 17'd0};
      num_w <= {30'd0, w_abs, 32'd0};
      neg_x <= (!sn[63] && sn != '0) ^ c0neg_s;
      neg_y <= cn[63] ^ c0neg_s;
      neg_w <= wsum_s[33];
      dxy <= {2'b00, den_xy};
      dom <= {2'b00, den_lr} + {1'b0, den_lr, 1'b0};
      sing_n <= sing_s;
    end
  end

  logic [omni3_pkg::QUOT_W-1:0] qx, qy, qw;
  logic ovx, ovy, ovw, ngx, ngy, ngw;

  omni3_div u_div_x (.clk(clk), .en(en), .num(num_x), .den(dxy), .neg_in(neg_x),
                     .quot(qx), .ovf(ovx), .neg(ngx));
  omni3_div u_div_y (.clk(clk), .en(en), .num(num_y), .den(dxy), .neg_in(neg_y),
                     .quot(qy), .ovf(ovy), .neg(ngy));
  omni3_div u_div_w (.clk(clk), .en(en), .num(num_w), .den(dom), .neg_in(neg_w),
                     .quot(qw), .ovf(ovw), .neg(ngw));

  always_ff @(posedge clk) begin
    if (en) begin
      sing_d <= {sing_d[DIV_LAT-2:0], sing_n};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sing_d[DIV_LAT-1]) begin
        result.speed_x <= '0;
        result.speed_y <= '0;
        result.turn_rate <= '0;
        result.singular <= 1'b1;
      end else begin
        result.speed_x <= omni3_pkg::sat_quot(qx, ovx, ngx);
        result.speed_y <= omni3_pkg::sat_quot(qy, ovy, ngy);
        result.turn_rate <= omni3_pkg::sat_quot(qw, ovw, ngw);
        result.singular <= 1'b0;
      end
    end
  end

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.singular |->
      result.speed_x == '0 && result.speed_y == '0 && result.turn_rate == '0)
    else $error("singular result with nonzero speeds");

  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  a_ready_tracks: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> sample.ready)
    else $error("input stalled while the output stage is empty");

endmodule

`default_nettype wire

>>> src/omni3_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detection.
`timescale 1ns / 1ps
`default_nettype none

module omni3_div (
  input  logic clk,
  input  logic en,
  input  logic [omni3_pkg::NUM_W-1:0] num,
  input  logic [omni3_pkg::DEN_W-1:0] den,
  input  logic neg_in,
  output logic [omni3_pkg::QUOT_W-1:0] quot,
  output logic ovf,
  output logic neg
);

  localparam int QW = omni3_pkg::QUOT_W;
  localparam int DW = omni3_pkg::DEN_W;
  localparam int NW = omni3_pkg::NUM_W;
  localparam int HW = NW - QW;

  logic [DW-1:0] rem [0:QW];
  logic [DW-1:0] dv [0:QW];
  logic [QW-1:0] qv [0:QW];
  logic [QW-1:0] nlo [0:QW];
  logic ov [0:QW];
  logic ng [0:QW];

  // The high part of the dividend must be below the divisor, else the quotient does not fit.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= DW'(num[NW-1:QW]);
      ov[0] <= {{(DW-HW){1'b0}}, num[NW-1:QW]} >= den;
      dv[0] <= den;
      qv[0] <= '0;
      nlo[0] <= num[QW-1:0];
      ng[0] <= neg_in;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW:0] trial;
    logic ge;
    assign trial = {rem[s], nlo[s][QW-1-s]};
    assign ge = trial >= {1'b0, dv[s]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? DW'(trial - {1'b0, dv[s]}) : trial[DW-1:0];
        qv[s+1] <= {qv[s][QW-2:0], ge};
        dv[s+1] <= dv[s];
        nlo[s+1] <= nlo[s];
        ov[s+1] <= ov[s];
        ng[s+1] <= ng[s];
      end
    end
  end

  assign quot = qv[QW];
  assign ovf = ov[QW];
  assign neg = ng[QW];

endmodule

`default_nettype wire

>>> tb/omni3_odometry_checker.sv
// Checker for the omni odometry block: predicts each motion result and compares it.
`timescale 1ns / 1ps

module omni3_odometry_checker (
  input  logic clk,
  input  logic rst,
  omni3_in_if samples,
  omni3_out_if results,
  input  logic wr_en,
  input  logic [omni3_pkg::IDX_W-1:0] wr_index,
  input  logic [31:0] wr_data,
  output int errors,
  output int pending
);
  import omni3_pkg::*;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] om;
    logic sing;
  } motion_t;

  localparam longint unsigned DIV_CAP = 64'h100_0000_0000;

  motion_t motion_q[$];
  logic [31:0] inv_radius;
  logic [31:0] center_dist;

  // Rounded arctangent of 2^-i in Q30 for the first steps; later steps are 2^(30-i).
  function automatic longint atan_step(input int i);
    longint tbl[11];
    tbl = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
            16775851, 8388437, 4194283, 2097149, 1048576};
    if (i < 11) return tbl[i];
    if (i <= 30) return longint'(1) << (30 - i);
    return 0;
  endfunction

  // Sine and cosine of a Q30 angle in Q29.
  function automatic void rotate(input longint ang, output longint sn, output longint cs);
    longint r, x, y, z, nx;
    bit flip;
    r = ang % longint'(TWO_PI_Q30);
    flip = 0;
    if (r > longint'(PI_Q30)) r -= longint'(TWO_PI_Q30);
    if (r < -longint'(PI_Q30)) r += longint'(TWO_PI_Q30);
    if (r > longint'(HALF_PI_Q30)) begin
      r -= longint'(PI_Q30);
      flip = 1;
    end else if (r < -longint'(HALF_PI_Q30)) begin
      r += longint'(PI_Q30);
      flip = 1;
    end
    x = longint'(GAIN_Q30);
    y = 0;
    z = r;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_step(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_step(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = x >>> 1;
    sn = y >>> 1;
  endfunction

  // Restoring division of n * 2^k by d, held at a cap once it grows past it.
  function automatic longint unsigned scaled_div(input longint unsigned n,
                                                 input longint unsigned d, input int k);
    longint unsigned rem, q, bitv;
    bit carry, sat;
    rem = 0;
    q = 0;
    sat = 0;
    for (int b = 0; b < 64 + k; b++) begin
      bitv = (b < 64) ? longint'(n[63-b]) : 0;
      carry = rem[63];
      rem = (rem << 1) | bitv;
      if (carry || rem >= d) begin
        rem -= d;
        bitv = 1;
      end else begin
        bitv = 0;
      end
      if (!sat) begin
        q = (q << 1) | bitv;
        if (q > DIV_CAP) sat = 1;
      end
    end
    return sat ? DIV_CAP : q;
  endfunction

  function automatic logic signed [31:0] sat_div(input longint num, input bit den_neg,
                                                 input longint unsigned den, input int k,
                                                 input longint unsigned post);
    longint unsigned mag, q;
    bit neg;
    mag = (num < 0) ? 64'd0 - 64'(num) : 64'(num);
    neg = (num < 0) != den_neg;
    q = scaled_div(mag, den, k) / post;
    if (neg) return (q > 64'd2147483648) ? 32'sh8000_0000 : -32'(q);
    return (q > 64'd2147483647) ? 32'sh7fff_ffff : 32'(q);
  endfunction

  function automatic motion_t solve_motion(input logic signed [31:0] w1,
                                           input logic signed [31:0] w2,
                                           input logic signed [31:0] w3,
                                           input logic signed [31:0] hd);
    longint h, sn, cn, wn, s, c, cos_h, w;
    longint unsigned cm, den;
    motion_t m;
    h = longint'(hd) * 4;
    sn = 0;
    cn = 0;
    wn = 0;
    cos_h = 0;
    for (int i = 0; i < 3; i++) begin
      rotate(h + ((i == 0) ? 0 : (i == 1) ? longint'(THIRD_TURN_Q30)
                                          : longint'(TWO_THIRD_TURN_Q30)), s, c);
      w = (i == 0) ? longint'(w1) : (i == 1) ? longint'(w2) : longint'(w3);
      if (i == 0) cos_h = c;
      sn += s * w;
      cn += c * w;
      wn += w;
    end
    m = '0;
    if (cos_h == 0 || center_dist == 0 || inv_radius == 0) begin
      m.sing = 1'b1;
      return m;
    end
    cm = (cos_h < 0) ? 64'(-cos_h) : 64'(cos_h);
    den = 3 * cm * 64'(inv_radius);
    m.vx = sat_div(-2 * sn, cos_h < 0, den, 16, 1);
    m.vy = sat_div(2 * cn, cos_h < 0, den, 16, 1);
    den = 64'(center_dist) * 64'(inv_radius);
    m.om = sat_div(wn, 1'b0, den, 32, 3);
    return m;
  endfunction

  assign pending = motion_q.size();

  always @(posedge clk) begin
    motion_t want, got;
    if (rst) begin
      inv_radius <= INV_RADIUS_RESET;
      center_dist <= CENTER_DIST_RESET;
      motion_q.delete();
      errors <= 0;
    end else begin
      if (wr_en) begin
        if (wr_index == REG_INV_RADIUS) inv_radius <= wr_data;
        else if (wr_index == REG_CENTER_DIST) center_dist <= wr_data;
      end
      if (samples.valid && samples.ready) begin
        motion_q.push_back(solve_motion(samples.wheel_speed_one, samples.wheel_speed_two,
                                        samples.wheel_speed_three, samples.heading));
      end
      if (results.valid && results.ready) begin
        got = '{results.speed_x, results.speed_y, results.turn_rate, results.singular};
        if (motion_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected: %p", $time, got);
          errors <= errors + 1;
        end else begin
          want = motion_q.pop_front();
          if (got != want) begin
            if (got.vx != want.vx)
              $display("%0t: speed_x expected %0d actual %0d", $time, want.vx, got.vx);
            if (got.vy != want.vy)
              $display("%0t: speed_y expected %0d actual %0d", $time, want.vy, got.vy);
            if (got.om != want.om)
              $display("%0t: turn_rate expected %0d actual %0d", $time, want.om, got.om);
            if (got.sing != want.sing)
              $display("%0t: singular expected %0b actual %0b", $time, want.sing, got.sing);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

>>> tb/omni_three_wheel_odometry_test.sv
// Stimulus and verdict for the omni odometry block, with the checker alongside.
`timescale 1ns / 1ps

module omni_three_wheel_odometry_test;
  import omni3_pkg::*;

  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT = 5000;
  localparam logic signed [31:0] QUARTER_TURN_Q28 = 32'sd421657428;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [IDX_W-1:0] wr_index = '0;
  logic [31:0] wr_data = '0;
  int errors, pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  omni3_in_if sample_ch();
  omni3_out_if result_ch();

  omni_three_wheel_odometry dut (
    .clk(clk), .rst(rst), .sample(sample_ch), .result(result_ch),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  omni3_odometry_checker checker_i (
    .clk(clk), .rst(rst), .samples(sample_ch), .results(result_ch),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.wheel_speed_one = '0;
    sample_ch.wheel_speed_two = '0;
    sample_ch.wheel_speed_three = '0;
    sample_ch.heading = '0;
    result_ch.ready = 1'b0;
  end

  always @(negedge clk) result_ch.ready <= ($urandom_range(99) >= stall_pct);

  // Watchdog: any stretch without a transfer on either channel this long is a hang.
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called just after a falling edge; returns just after the falling edge following the transfer.
  task automatic send_sample(input logic signed [31:0] w1, input logic signed [31:0] w2,
                             input logic signed [31:0] w3, input logic signed [31:0] hd);
    while ($urandom_range(99) < idle_pct) begin
      sample_ch.valid = 1'b0;
      @(negedge clk);
    end
    sample_ch.valid = 1'b1;
    sample_ch.wheel_speed_one = w1;
    sample_ch.wheel_speed_two = w2;
    sample_ch.wheel_speed_three = w3;
    sample_ch.heading = hd;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  task automatic settle();
    sample_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_speed();
    logic signed [31:0] v;
    v = $urandom();
    if ($urandom_range(1)) v = v >>> $urandom_range(31);
    return v;
  endfunction

  function automatic logic signed [31:0] rand_heading();
    logic signed [31:0] h;
    if ($urandom_range(3) == 0) begin
      // Near a quarter turn the cosine of the heading can come out exactly zero.
      h = QUARTER_TURN_Q28 + $signed($urandom_range(8)) - 4;
      return $urandom_range(1) ? -h : h;
    end
    h = $urandom();
    return h;
  endfunction

  initial begin
    logic [31:0] radii[5];
    logic [31:0] dists[5];
    radii = '{INV_RADIUS_RESET, 32'd1, 32'hffff_ffff, 32'd1, 32'd0};
    dists = '{CENTER_DIST_RESET, 32'd0, 32'hffff_ffff, 32'd1, 32'd0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int phase = 0; phase < 5; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 70; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 70; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      if (phase > 0) begin
        settle();
        if (phase == 4) begin
          radii[4] = $urandom_range(32'h0020_0000, 1);
          dists[4] = $urandom();
          write_reg(IDX_W'(7), $urandom());
        end
        write_reg(REG_INV_RADIUS, radii[phase]);
        write_reg(REG_CENTER_DIST, dists[phase]);
      end

      if (phase == 0) begin
        send_sample(0, 0, 0, 0);
        send_sample(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
        send_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
        send_sample(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_sample(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000);
        send_sample(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, QUARTER_TURN_Q28);
        send_sample(32'sh0001_0000, -32'sh0001_0000, 0, -QUARTER_TURN_Q28);
        send_sample(32'sh0001_0000, 0, 0, QUARTER_TURN_Q28 + 1);
        send_sample(0, 32'sh0001_0000, 0, QUARTER_TURN_Q28 - 1);
        send_sample(0, 0, 32'sh0001_0000, 2 * QUARTER_TURN_Q28);
        send_sample(32'sh7fff_ffff, 0, 32'sh8000_0000, 4 * QUARTER_TURN_Q28);
        send_sample(32'sh0000_0001, 32'shffff_ffff, 32'sh0000_0001, 32'sh1000_0000);
        send_sample(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh1234_5678, 32'shedcb_a988);
        send_sample(32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff);
        send_sample(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, QUARTER_TURN_Q28 - 2);
      end

      for (int n = 0; n < 140; n++) begin
        // For the last samples of each phase run a stretch with no idling and no stalls at all.
        if (n == 100) begin idle_pct = 0; stall_pct = 0; end
        send_sample(rand_speed(), rand_speed(), rand_speed(), rand_heading());
      end
    end

    settle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
